@@ rtl/arxpm_pkg.sv @@
package arxpm_pkg;

    localparam int DATA_W      = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_LANES  = 3;
    localparam int PACK_W      = COEF_W * COEF_LANES;
    localparam int DELAY_W     = 5;
    localparam int PROD_W      = DATA_W + COEF_W;
    localparam int FRAC_SHIFT  = 13;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;

    localparam int DEF_A_TAPS        = 3;
    localparam int DEF_B_TAPS        = 3;
    localparam int DEF_HISTORY_DEPTH = 32;

    localparam logic [PACK_W-1:0]         RST_A_COEF   = 48'h0000_0000_F333;
    localparam logic [PACK_W-1:0]         RST_B_COEF   = 48'h0000_0000_1333;
    localparam logic [DELAY_W-1:0]        RST_DELAY    = 5'd1;
    localparam logic signed [DATA_W-1:0]  RST_LOW_LIM  = -16'sd10240;
    localparam logic signed [DATA_W-1:0]  RST_HIGH_LIM = 16'sd10240;

    typedef enum logic [2:0] {
        REG_A_COEF   = 3'd0,
        REG_B_COEF   = 3'd1,
        REG_DELAY    = 3'd2,
        REG_IN_LOW   = 3'd3,
        REG_IN_HIGH  = 3'd4,
        REG_OUT_LOW  = 3'd5,
        REG_OUT_HIGH = 3'd6,
        REG_LIM_EN   = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE_B,
        ST_ISSUE_A,
        ST_DRAIN,
        ST_DRAIN2,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_sample;
        logic clear_hist;
        logic issue_b;
        logic issue_a;
        logic round;
        logic finish;
        logic push_hist;
    } dp_cmd_t;

    // Pick one signed lane of a packed coefficient word; lanes past the third are zero.
    function automatic logic signed [COEF_W-1:0] coef_lane(input logic [PACK_W-1:0] coefs,
                                                          input int unsigned idx);
        logic signed [COEF_W-1:0] lane_val;
        lane_val = '0;
        if (idx < COEF_LANES) begin
            lane_val = coefs[idx*COEF_W +: COEF_W];
        end
        return lane_val;
    endfunction

    // Raise to low, then lower to high: high wins when the limits cross.
    function automatic logic signed [DATA_W-1:0] clamp16(input logic signed [DATA_W-1:0] v,
                                                        input logic signed [DATA_W-1:0] lo,
                                                        input logic signed [DATA_W-1:0] hi);
        logic signed [DATA_W-1:0] r;
        r = v;
        if (r < lo) begin
            r = lo;
        end
        if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

@@ rtl/arxpm_ctrl.sv @@
module arxpm_ctrl
    import arxpm_pkg::*;
#(
    parameter int A_TAPS = DEF_A_TAPS,
    parameter int B_TAPS = DEF_B_TAPS,
    parameter int CNT_W  = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_mode,
    output logic             s_ready,
    input  logic             out_free,
    output dp_cmd_t          cmd,
    output logic [CNT_W-1:0] tap_cnt
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             clear_item_reg, clear_item_next;
    logic             b_last, a_last;

    assign b_last  = (cnt_reg == CNT_W'(B_TAPS - 1));
    assign a_last  = (cnt_reg == CNT_W'(A_TAPS - 1));
    assign tap_cnt = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            clear_item_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            clear_item_reg <= clear_item_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_mode ? ST_DONE : ST_ISSUE_B;
                end
            end
            ST_ISSUE_B: begin
                if (b_last) begin
                    state_next = ST_ISSUE_A;
                end
            end
            ST_ISSUE_A: begin
                if (a_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next        = cnt_reg;
        clear_item_next = clear_item_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    clear_item_next = s_mode;
                end
            end
            ST_ISSUE_B: cnt_next = b_last ? '0 : cnt_reg + 1'b1;
            ST_ISSUE_A: cnt_next = a_last ? '0 : cnt_reg + 1'b1;
            default:    cnt_next = '0;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_sample = s_valid && !s_mode;
                cmd.clear_hist  = s_valid && s_mode;
            end
            ST_ISSUE_B: cmd.issue_b = 1'b1;
            ST_ISSUE_A: cmd.issue_a = 1'b1;
            ST_ROUND:   cmd.round   = 1'b1;
            ST_DONE: begin
                cmd.finish    = out_free;
                cmd.push_hist = out_free && !clear_item_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && !s_mode) |=> (state_reg == ST_ISSUE_B))
        else $error("simulate transaction did not start the B taps");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && s_mode) |=> (state_reg == ST_DONE && clear_item_reg))
        else $error("clear transaction did not go straight to completion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE_A) |-> (cnt_reg <= CNT_W'(A_TAPS - 1)))
        else $error("A tap counter overran");

endmodule

@@ rtl/arxpm_dp.sv @@
module arxpm_dp
    import arxpm_pkg::*;
#(
    parameter int A_TAPS        = DEF_A_TAPS,
    parameter int B_TAPS        = DEF_B_TAPS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int CNT_W         = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    input  logic [CNT_W-1:0]         tap_cnt,
    input  logic signed [DATA_W-1:0] s_control_input,
    input  logic [PACK_W-1:0]        a_coefs,
    input  logic [PACK_W-1:0]        b_coefs,
    input  logic [DELAY_W-1:0]       delay,
    input  logic signed [DATA_W-1:0] in_low,
    input  logic signed [DATA_W-1:0] in_high,
    input  logic signed [DATA_W-1:0] out_low,
    input  logic signed [DATA_W-1:0] out_high,
    input  logic                     lim_en,
    output logic                     out_free,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_model_output
);

    localparam int PTR_W    = $clog2(HISTORY_DEPTH);
    localparam int DMAX_RAW = HISTORY_DEPTH - B_TAPS - 1;
    localparam int DMAX     = (DMAX_RAW < 1) ? 1 : DMAX_RAW;
    localparam int ACC_W    = PROD_W + $clog2(A_TAPS + B_TAPS) + 1;
    localparam int RND_W    = ACC_W + 1 - FRAC_SHIFT;

    // input history store, one write and one registered read a cycle
    logic [DATA_W-1:0]        mem [HISTORY_DEPTH];
    logic [DATA_W-1:0]        mem_rd_reg;
    logic [HISTORY_DEPTH-1:0] hit_bits_reg;

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0] d_eff, rd_start, rd_dec, wr_inc;

    logic signed [DATA_W-1:0] out_hist_reg [A_TAPS];

    logic signed [COEF_W-1:0] coef_s1_reg;
    logic signed [DATA_W-1:0] hist_s1_reg;
    logic                     mem_src_s1_reg, hit_s1_reg, sub_s1_reg, vld_s1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     sub_s2_reg, vld_s2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_out_reg;

    logic signed [DATA_W-1:0] u_clamped;
    logic signed [DATA_W-1:0] hist_sel, sample_s1;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [ACC_W:0]    acc_biased;
    logic signed [RND_W-1:0]  rounded, limited;
    logic signed [DATA_W-1:0] y_sat;

    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_model_output = m_out_reg;

    assign u_clamped = lim_en ? clamp16(s_control_input, in_low, in_high) : s_control_input;

    always_comb begin
        if (delay == '0) begin
            d_eff = PTR_W'(1);
        end else if (int'(delay) > DMAX) begin
            d_eff = PTR_W'(DMAX);
        end else begin
            d_eff = PTR_W'(delay);
        end
    end

    assign rd_start = (wr_ptr_reg >= d_eff) ? wr_ptr_reg - d_eff
                                            : wr_ptr_reg + PTR_W'(HISTORY_DEPTH) - d_eff;
    assign rd_dec   = (rd_ptr_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
    assign wr_inc   = (wr_ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    always_comb begin
        hist_sel = '0;
        for (int i = 0; i < A_TAPS; i++) begin
            if (tap_cnt == CNT_W'(i)) begin
                hist_sel = out_hist_reg[i];
            end
        end
    end

    assign coef_sel = cmd.issue_b ? coef_lane(b_coefs, int'(tap_cnt))
                                  : coef_lane(a_coefs, int'(tap_cnt));

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            mem[wr_ptr_reg] <= u_clamped;
        end
        mem_rd_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_bits_reg <= '0;
            wr_ptr_reg   <= '0;
        end else if (cmd.clear_hist) begin
            hit_bits_reg <= '0;
            wr_ptr_reg   <= '0;
        end else if (cmd.load_sample) begin
            hit_bits_reg[wr_ptr_reg] <= 1'b1;
            wr_ptr_reg               <= wr_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            rd_ptr_reg <= rd_start;
        end else if (cmd.issue_b) begin
            rd_ptr_reg <= rd_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_hist) begin
            for (int i = 0; i < A_TAPS; i++) begin
                out_hist_reg[i] <= '0;
            end
        end else if (cmd.push_hist) begin
            out_hist_reg[0] <= y_reg;
            for (int i = 1; i < A_TAPS; i++) begin
                out_hist_reg[i] <= out_hist_reg[i-1];
            end
        end
    end

    // operand stage, multiply stage, accumulate stage
    always_ff @(posedge aclk) begin
        coef_s1_reg    <= coef_sel;
        hist_s1_reg    <= hist_sel;
        mem_src_s1_reg <= cmd.issue_b;
        hit_s1_reg     <= hit_bits_reg[rd_ptr_reg];
        sub_s1_reg     <= cmd.issue_a;
        prod_reg       <= coef_s1_reg * sample_s1;
        sub_s2_reg     <= sub_s1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
        end else begin
            vld_s1_reg <= cmd.issue_b || cmd.issue_a;
            vld_s2_reg <= vld_s1_reg;
        end
    end

    assign sample_s1 = mem_src_s1_reg ? (hit_s1_reg ? $signed(mem_rd_reg) : '0) : hist_s1_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            acc_reg <= '0;
        end else if (vld_s2_reg) begin
            if (sub_s2_reg) begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // round half up to Q5.10, clamp, saturate
    assign acc_biased = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(1 << (FRAC_SHIFT - 1));
    assign rounded    = RND_W'(acc_biased >>> FRAC_SHIFT);

    always_comb begin
        limited = rounded;
        if (lim_en) begin
            if (limited < RND_W'(out_low)) begin
                limited = RND_W'(out_low);
            end
            if (limited > RND_W'(out_high)) begin
                limited = RND_W'(out_high);
            end
        end
        if (limited < RND_W'(-(1 <<< (DATA_W - 1)))) begin
            y_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else if (limited > RND_W'((1 <<< (DATA_W - 1)) - 1)) begin
            y_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end else begin
            y_sat = DATA_W'(limited);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_hist) begin
            y_reg <= '0;
        end else if (cmd.round) begin
            y_reg <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_out_reg <= y_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round |-> (!vld_s1_reg && !vld_s2_reg))
        else $error("rounding started before the MAC pipeline drained");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result appeared without a finish command");

endmodule

@@ rtl/arx_plant_model_step.sv @@
// ARX plant model with transport delay. Each simulate transaction takes a Q5.10
// control sample, clamps it to the input limits when limiting is on, stores it in
// the input history and returns y = sum B[i]*u(k-d-i) - sum A[i]*y(k-1-i),
// rounded half up to Q5.10 and then clamped to the output limits (limiting on)
// or saturated to 16 bits (limiting off). A clear transaction empties both
// histories at once and returns 0. In a simulate transaction one multiplier is
// shared by all taps, one tap per cycle, behind a three-deep pipeline of read,
// multiply and accumulate, followed by a rounding step. A clear transaction goes
// straight from idle to completion. A new transaction is accepted as soon as the
// controller is back in idle, even while the previous result still waits in the
// output register. No clearing pass follows reset. Configuration is an APB port
// with 64-bit data; register i sits at byte address 8*i.
// Write configuration only while the block is idle.
module arx_plant_model_step
    import arxpm_pkg::*;
#(
    parameter int A_TAPS        = DEF_A_TAPS,
    parameter int B_TAPS        = DEF_B_TAPS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // config port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready,
    // sample channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_mode,
    input  logic signed [DATA_W-1:0] s_control_input,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_model_output
);

    localparam int MAX_TAPS = (A_TAPS > B_TAPS) ? A_TAPS : B_TAPS;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);

    logic [PACK_W-1:0]        a_coef_reg, b_coef_reg;
    logic [DELAY_W-1:0]       delay_reg;
    logic signed [DATA_W-1:0] in_low_reg, in_high_reg, out_low_reg, out_high_reg;
    logic                     lim_en_reg;

    cfg_reg_t         reg_sel;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    logic [CNT_W-1:0] tap_cnt;
    logic             out_free;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register write: take the low bits of the data, ignore the rest.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_coef_reg   <= RST_A_COEF;
            b_coef_reg   <= RST_B_COEF;
            delay_reg    <= RST_DELAY;
            in_low_reg   <= RST_LOW_LIM;
            in_high_reg  <= RST_HIGH_LIM;
            out_low_reg  <= RST_LOW_LIM;
            out_high_reg <= RST_HIGH_LIM;
            lim_en_reg   <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_A_COEF:   a_coef_reg   <= pwdata[PACK_W-1:0];
                REG_B_COEF:   b_coef_reg   <= pwdata[PACK_W-1:0];
                REG_DELAY:    delay_reg    <= pwdata[DELAY_W-1:0];
                REG_IN_LOW:   in_low_reg   <= pwdata[DATA_W-1:0];
                REG_IN_HIGH:  in_high_reg  <= pwdata[DATA_W-1:0];
                REG_OUT_LOW:  out_low_reg  <= pwdata[DATA_W-1:0];
                REG_OUT_HIGH: out_high_reg <= pwdata[DATA_W-1:0];
                REG_LIM_EN:   lim_en_reg   <= pwdata[0];
                default:      lim_en_reg   <= lim_en_reg;
            endcase
        end
    end

    // Read back: zero-extend each register to the bus width.
    always_comb begin
        unique case (reg_sel)
            REG_A_COEF:   prdata = CFG_DATA_W'(a_coef_reg);
            REG_B_COEF:   prdata = CFG_DATA_W'(b_coef_reg);
            REG_DELAY:    prdata = CFG_DATA_W'(delay_reg);
            REG_IN_LOW:   prdata = CFG_DATA_W'($unsigned(in_low_reg));
            REG_IN_HIGH:  prdata = CFG_DATA_W'($unsigned(in_high_reg));
            REG_OUT_LOW:  prdata = CFG_DATA_W'($unsigned(out_low_reg));
            REG_OUT_HIGH: prdata = CFG_DATA_W'($unsigned(out_high_reg));
            REG_LIM_EN:   prdata = CFG_DATA_W'(lim_en_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequence the taps through the shared MAC.
    arxpm_ctrl #(
        .A_TAPS (A_TAPS),
        .B_TAPS (B_TAPS),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_mode   (s_mode),
        .s_ready  (s_ready),
        .out_free (out_free),
        .cmd      (cmd),
        .tap_cnt  (tap_cnt)
    );

    // Histories, MAC pipeline, rounding and the output register.
    arxpm_dp #(
        .A_TAPS        (A_TAPS),
        .B_TAPS        (B_TAPS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CNT_W         (CNT_W)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .tap_cnt         (tap_cnt),
        .s_control_input (s_control_input),
        .a_coefs         (a_coef_reg),
        .b_coefs         (b_coef_reg),
        .delay           (delay_reg),
        .in_low          (in_low_reg),
        .in_high         (in_high_reg),
        .out_low         (out_low_reg),
        .out_high        (out_high_reg),
        .lim_en          (lim_en_reg),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_model_output  (m_model_output)
    );

endmodule

@@ bench/arx_plant_model_step_test.sv @@
`timescale 1ns / 100ps

module arx_plant_model_step_test;
    import arxpm_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;      // receiver hold-off that backs up the block
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 150;
    localparam int ERROR_PRINTS  = 200;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // History geometry of the default build: 32 input slots, three taps on each side.
    localparam int LAG_CEIL = 32 - 3 - 1;

    localparam logic MODE_STEP  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Values the configuration registers take out of reset.
    localparam logic [PACK_W-1:0]        A_AT_RESET   = 48'h0000_0000_F333;
    localparam logic [PACK_W-1:0]        B_AT_RESET   = 48'h0000_0000_1333;
    localparam logic [DELAY_W-1:0]       LAG_AT_RESET = 5'd1;
    localparam logic signed [DATA_W-1:0] LIM_AT_RESET = 16'sd10240;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_W-1:0]     paddr;
    logic [CFG_DATA_W-1:0]     pwdata;
    logic [CFG_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_mode;
    logic signed [DATA_W-1:0]  s_control_input;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DATA_W-1:0]  m_model_output;

    arx_plant_model_step dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_control_input (s_control_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_model_output  (m_model_output)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Plant predictor: its own copy of the configuration and histories.
    // ------------------------------------------------------------------
    logic [PACK_W-1:0]        a_pack;
    logic [PACK_W-1:0]        b_pack;
    logic [DELAY_W-1:0]       lag_cfg;
    logic signed [DATA_W-1:0] in_lo;
    logic signed [DATA_W-1:0] in_hi;
    logic signed [DATA_W-1:0] out_lo;
    logic signed [DATA_W-1:0] out_hi;
    logic                     lim_on;

    logic signed [DATA_W-1:0] u_hist [32];
    logic signed [DATA_W-1:0] y_hist [3];
    logic [4:0]               u_slot;

    // Outputs still owed by the block, oldest first.
    logic signed [DATA_W-1:0] y_pending [$];

    // Side information for the transaction now on the input channel: a directed
    // row may carry an output that is known without the predictor.
    logic                     pin_known = 1'b0;
    logic signed [DATA_W-1:0] pin_y = '0;

    int  errors = 0;
    int  result_count = 0;
    bit  hold_request = 1'b0;
    bit  calm_tx = 1'b0;
    bit  calm_rx = 1'b0;

    function automatic void wipe_histories();
        foreach (u_hist[i]) begin
            u_hist[i] = '0;
        end
        foreach (y_hist[i]) begin
            y_hist[i] = '0;
        end
        u_slot = '0;
    endfunction

    function automatic void reset_plant();
        a_pack  = A_AT_RESET;
        b_pack  = B_AT_RESET;
        lag_cfg = LAG_AT_RESET;
        in_lo   = -LIM_AT_RESET;
        in_hi   = LIM_AT_RESET;
        out_lo  = -LIM_AT_RESET;
        out_hi  = LIM_AT_RESET;
        lim_on  = 1'b1;
        wipe_histories();
    endfunction

    // Advance the plant by one transaction and return the output it produces.
    function automatic logic signed [DATA_W-1:0] plant_step(input logic mode,
                                                            input logic signed [DATA_W-1:0] u);
        logic signed [DATA_W-1:0] u_held;
        logic [4:0]               cur;
        int                       lag;
        longint                   acc;
        longint                   y;
        if (mode == MODE_CLEAR) begin
            wipe_histories();
            return '0;
        end
        u_held = u;
        if (lim_on) begin
            if (u_held < in_lo) begin
                u_held = in_lo;
            end
            if (u_held > in_hi) begin
                u_held = in_hi;
            end
        end
        cur = u_slot;
        u_hist[cur] = u_held;
        u_slot = cur + 5'd1;

        // A zero delay behaves as one; anything past the history reach pins to it.
        lag = int'(lag_cfg);
        if (lag < 1) begin
            lag = 1;
        end
        if (lag > LAG_CEIL) begin
            lag = LAG_CEIL;
        end

        acc = 0;
        for (int i = 0; i < 3; i++) begin
            acc += longint'($signed(b_pack[16*i +: 16])) * longint'(u_hist[cur - 5'(lag + i)]);
            acc -= longint'($signed(a_pack[16*i +: 16])) * longint'(y_hist[i]);
        end

        // Q7.23 down to Q5.10, halves toward plus infinity.
        y = (acc + 64'sd4096) >>> 13;
        if (lim_on) begin
            if (y < longint'(out_lo)) begin
                y = out_lo;
            end
            if (y > longint'(out_hi)) begin
                y = out_hi;
            end
        end
        if (y < -32768) begin
            y = -32768;
        end
        if (y > 32767) begin
            y = 32767;
        end
        y_hist[2] = y_hist[1];
        y_hist[1] = y_hist[0];
        y_hist[0] = DATA_W'(y);
        return DATA_W'(y);
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= ERROR_PRINTS) begin
            $display("mismatch: %s", what);
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: check results, then predict newly accepted transactions.
    // Compare first so a result never meets an expectation pushed on the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        logic signed [DATA_W-1:0] want;
        logic signed [DATA_W-1:0] predicted;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (y_pending.size() == 0) begin
                    flag_error($sformatf("result %0d (%0d) arrived with nothing pending",
                                         result_count, m_model_output));
                end else begin
                    want = y_pending[0];
                    y_pending.delete(0);
                    if (m_model_output !== want) begin
                        flag_error($sformatf("model_output of result %0d: got %0d, want %0d",
                                             result_count, m_model_output, want));
                    end
                end
                result_count++;
            end
            if (s_valid && s_ready) begin
                predicted = plant_step(s_mode, s_control_input);
                y_pending.insert(y_pending.size(), pin_known ? pin_y : predicted);
            end
        end
    end

    // Wait count for one side: mostly uniform 0..14, with runs of back-to-back traffic.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off when asked for.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = draw_wait(calm_rx);
            if (hold_request) begin
                // Hold off long enough for the block to back up into its input.
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Input side and configuration. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------
    task automatic offer(input logic mode, input logic signed [DATA_W-1:0] u,
                         input logic known, input logic signed [DATA_W-1:0] y);
        int gap;
        gap = draw_wait(calm_tx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_control_input <= u;
        pin_known = known;
        pin_y     = y;
        // Hold the transaction until the block takes it.
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, drain every pending result, then give the block time to go idle.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (y_pending.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t target, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(target) << CFG_IDX_LSB;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Mirror the write; bits above each register's width are dropped.
        case (target)
            REG_A_COEF:   a_pack  = value[PACK_W-1:0];
            REG_B_COEF:   b_pack  = value[PACK_W-1:0];
            REG_DELAY:    lag_cfg = value[DELAY_W-1:0];
            REG_IN_LOW:   in_lo   = value[DATA_W-1:0];
            REG_IN_HIGH:  in_hi   = value[DATA_W-1:0];
            REG_OUT_LOW:  out_lo  = value[DATA_W-1:0];
            REG_OUT_HIGH: out_hi  = value[DATA_W-1:0];
            REG_LIM_EN:   lim_on  = value[0];
            default: ;
        endcase
    endtask

    // Fill the unused upper bits of a register write with noise.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int width);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] mask;
        junk = {$urandom, $urandom};
        mask = (64'd1 << width) - 64'd1;
        return (junk & ~mask) | (v & mask);
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            5: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 6000)) - 3000);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_input();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return DATA_W'(int'($urandom_range(0, 4096)) - 2048);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic pick_limits(output logic [15:0] lo, output logic [15:0] hi);
        case ($urandom_range(0, 4))
            0: begin
                lo = 16'h8000;
                hi = 16'h7FFF;
            end
            1: begin
                // Either order, so the limits may cross.
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            default: begin
                lo = 16'(-int'($urandom_range(0, 32768)));
                hi = 16'($urandom_range(0, 32767));
            end
        endcase
    endtask

    // Rewrite every register for the next random phase; two phases sit at the extremes.
    task automatic apply_settings(input int phase_idx);
        logic [PACK_W-1:0]  a_val;
        logic [PACK_W-1:0]  b_val;
        logic [DELAY_W-1:0] d_val;
        logic [15:0]        il;
        logic [15:0]        ih;
        logic [15:0]        ol;
        logic [15:0]        oh;
        logic               en;
        case (phase_idx)
            1: begin
                a_val = {3{16'h8000}};
                b_val = {3{16'h7FFF}};
                d_val = 5'd31;
                il = 16'h8000;
                ih = 16'h7FFF;
                ol = 16'h8000;
                oh = 16'h7FFF;
                en = 1'b0;
            end
            7: begin
                a_val = '0;
                b_val = {3{16'h8000}};
                d_val = 5'd28;
                il = 16'h8000;
                ih = 16'h7FFF;
                ol = 16'h8000;
                oh = 16'h7FFF;
                en = 1'b1;
            end
            default: begin
                a_val = {pick_coef(), pick_coef(), pick_coef()};
                b_val = {pick_coef(), pick_coef(), pick_coef()};
                d_val = DELAY_W'($urandom_range(0, 31));
                pick_limits(il, ih);
                pick_limits(ol, oh);
                en = 1'($urandom_range(0, 1));
            end
        endcase
        write_reg(REG_A_COEF,   with_junk(64'(a_val), PACK_W));
        write_reg(REG_B_COEF,   with_junk(64'(b_val), PACK_W));
        write_reg(REG_DELAY,    with_junk(64'(d_val), DELAY_W));
        write_reg(REG_IN_LOW,   with_junk(64'(il), DATA_W));
        write_reg(REG_IN_HIGH,  with_junk(64'(ih), DATA_W));
        write_reg(REG_OUT_LOW,  with_junk(64'(ol), DATA_W));
        write_reg(REG_OUT_HIGH, with_junk(64'(oh), DATA_W));
        write_reg(REG_LIM_EN,   with_junk(64'(en), 1));
    endtask

    // ------------------------------------------------------------------
    // Directed rows. A known output is given only where it is obvious:
    // empty histories, a clear, or crossed output limits pinning y to the high one.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        ROW_STEP,
        ROW_CLEAR,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        cfg_reg_t                 target;
        logic [CFG_DATA_W-1:0]    value;
        logic signed [DATA_W-1:0] u;
        logic                     known;
        logic signed [DATA_W-1:0] y;
    } row_t;

    localparam int PLAN_ROWS = 32;

    row_t plan [PLAN_ROWS] = '{
        // reset settings: first sample sees only empty history
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b1, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh8000, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  -16'sd1,   1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sd0,    1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sd1,    1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sd12345, 1'b0, 16'sd0},
        '{ROW_CLEAR, REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b1, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh8000, 1'b1, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b0, 16'sd0},
        // limits off, strongest coefficients: drive the output into saturation
        '{ROW_WRITE, REG_LIM_EN,   64'hA5A5_0000_0000_0000, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_B_COEF,   64'hFFFF_7FFF_7FFF_7FFF, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_A_COEF,   64'h1234_8000_8000_8000, 16'sd0,   1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh8000, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh8000, 1'b0, 16'sd0},
        // zero delay acts as one
        '{ROW_WRITE, REG_DELAY,    64'h0000_0000_0000_00E0, 16'sd0,   1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sd20000, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  -16'sd20000, 1'b0, 16'sd0},
        // largest code pins to the history reach
        '{ROW_WRITE, REG_DELAY,    64'hFFFF_FFFF_FFFF_FFFF, 16'sd0,   1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sd100,  1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  -16'sd100, 1'b0, 16'sd0},
        // crossed limits: the high limit wins on both sides
        '{ROW_WRITE, REG_LIM_EN,   64'h8000_0000_0000_0003, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_IN_LOW,   64'h0000_0000_0000_03E8, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_IN_HIGH,  64'h7777_0000_0000_FC18, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_OUT_LOW,  64'h0000_0000_0000_01F4, 16'sd0,   1'b0, 16'sd0},
        '{ROW_WRITE, REG_OUT_HIGH, 64'h0000_0000_FFFF_FE0C, 16'sd0,   1'b0, 16'sd0},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh7FFF, 1'b1, -16'sd500},
        '{ROW_STEP,  REG_A_COEF,   64'h0,                  16'sh8000, 1'b1, -16'sd500},
        '{ROW_CLEAR, REG_A_COEF,   64'h0,                  16'sd0,    1'b1, 16'sd0}
    };

    initial begin : stimulus
        logic                     mode_pick;
        logic signed [DATA_W-1:0] u_pick;
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_valid         = 1'b0;
        s_mode          = MODE_STEP;
        s_control_input = '0;
        reset_plant();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed rows; registers change only once the block is idle.
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WRITE) begin
                quiesce();
                write_reg(plan[k].target, plan[k].value);
            end else begin
                offer(plan[k].kind == ROW_CLEAR ? MODE_CLEAR : MODE_STEP,
                      plan[k].u, plan[k].known, plan[k].y);
            end
        end

        // Random phases: long runs of samples so the histories wrap, rare clears.
        for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            quiesce();
            apply_settings(phase_idx);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 40 && (phase_idx == 3 || phase_idx == 8)) begin
                    hold_request = 1'b1;
                end
                mode_pick = ($urandom_range(0, 39) == 0) ? MODE_CLEAR : MODE_STEP;
                u_pick    = pick_input();
                offer(mode_pick, u_pick, 1'b0, '0);
            end
        end

        quiesce();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
